FILE: rtl/assert_macros.svh
// assertion helpers for the lexer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define LX_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("lexer check failed");
// condition that must hold in the cycle after a trigger
`define LX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) ante |=> cons) \
		else $error("lexer check failed");
`else
`define LX_ASSERT(lbl, clk, rstn, prop)
`define LX_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/lx_pkg.sv
`timescale 1ns / 1ps
package lx_pkg;

	// result kinds
	localparam logic [5:0] K_OP    = 6'd1;
	localparam logic [5:0] K_DELIM = 6'd2;
	localparam logic [5:0] K_KW    = 6'd3;
	localparam logic [5:0] K_IDENT = 6'd4;
	localparam logic [5:0] K_ICHAR = 6'd5;
	localparam logic [5:0] K_INT   = 6'd6;
	localparam logic [5:0] K_FLOAT = 6'd7;
	localparam logic [5:0] K_SCHAR = 6'd8;
	localparam logic [5:0] K_SEND  = 6'd9;
	localparam logic [5:0] K_ERR   = 6'd10;
	localparam logic [5:0] K_END   = 6'd11;

	// error codes
	localparam logic [1:0] E_CHAR    = 2'd1;
	localparam logic [1:0] E_STRING  = 2'd2;
	localparam logic [1:0] E_COMMENT = 2'd3;

	// operator numbers
	localparam logic [4:0] OP_ELLIPSIS = 5'd0;
	localparam logic [4:0] OP_ARROW    = 5'd1;
	localparam logic [4:0] OP_SHL      = 5'd2;
	localparam logic [4:0] OP_SHR      = 5'd3;
	localparam logic [4:0] OP_LE       = 5'd4;
	localparam logic [4:0] OP_GE       = 5'd5;
	localparam logic [4:0] OP_EQ       = 5'd6;
	localparam logic [4:0] OP_NE       = 5'd7;
	localparam logic [4:0] OP_LAND     = 5'd8;
	localparam logic [4:0] OP_LOR      = 5'd9;
	localparam logic [4:0] OP_PLUS     = 5'd10;
	localparam logic [4:0] OP_MINUS    = 5'd11;
	localparam logic [4:0] OP_STAR     = 5'd12;
	localparam logic [4:0] OP_SLASH    = 5'd13;
	localparam logic [4:0] OP_PERCENT  = 5'd14;
	localparam logic [4:0] OP_ASSIGN   = 5'd15;
	localparam logic [4:0] OP_NOT      = 5'd16;
	localparam logic [4:0] OP_LT       = 5'd17;
	localparam logic [4:0] OP_GT       = 5'd18;
	localparam logic [4:0] OP_AND      = 5'd19;
	localparam logic [4:0] OP_OR       = 5'd20;
	localparam logic [4:0] OP_XOR      = 5'd21;
	localparam logic [4:0] OP_INC      = 5'd22;
	localparam logic [4:0] OP_DEC      = 5'd23;

	// delimiter numbers
	localparam logic [2:0] D_LPAREN = 3'd0;
	localparam logic [2:0] D_RPAREN = 3'd1;
	localparam logic [2:0] D_LBRACE = 3'd2;
	localparam logic [2:0] D_RBRACE = 3'd3;
	localparam logic [2:0] D_COLON  = 3'd4;
	localparam logic [2:0] D_COMMA  = 3'd5;
	localparam logic [2:0] D_DOT    = 3'd6;
	localparam logic [2:0] D_SEMI   = 3'd7;

	localparam logic [30:0] VAL_MAX = 31'h7fff_ffff;
	localparam int KW_NUM = 18;

	// keywords, right aligned, first char is the highest byte in use
	localparam logic [63:0] KW_TEXT [KW_NUM] = '{
		64'("const"), 64'("continue"), 64'("do"), 64'("else"), 64'("enum"),
		64'("float"), 64'("for"), 64'("if"), 64'("int"), 64'("return"),
		64'("sizeof"), 64'("struct"), 64'("switch"), 64'("unsigned"),
		64'("void"), 64'("while"), 64'("bool"), 64'("string")};
	localparam logic [3:0] KW_LEN [KW_NUM] = '{
		4'd5, 4'd8, 4'd2, 4'd4, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd4, 4'd5, 4'd4, 4'd6};

	typedef struct packed {
		logic [5:0]  kind;
		logic [30:0] value;
		logic [4:0]  frac_digits;
		logic [15:0] line;
		logic [15:0] column;
	} lx_res_t;

	typedef struct packed {
		logic    push;
		logic    step_end;
		lx_res_t res;
	} lx_buf_ctl_t;

	typedef struct packed {
		logic       hit;
		logic [4:0] code;
	} lx_op_t;

	function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
		logic [7:0] ch;
		ch = 8'd0;
		if ({1'b0, i} < KW_LEN[k])
			ch = KW_TEXT[k][(int'(KW_LEN[k]) - 1 - int'(i)) * 8 +: 8];
		return ch;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic is_ident(input logic [7:0] c);
		return is_alpha(c) || is_digit(c);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0c || c == 8'h0b;
	endfunction

	function automatic lx_op_t one_op(input logic [7:0] c);
		lx_op_t r;
		r.hit = 1'b1;
		case (c)
			"+": r.code = OP_PLUS;
			"-": r.code = OP_MINUS;
			"*": r.code = OP_STAR;
			"/": r.code = OP_SLASH;
			"%": r.code = OP_PERCENT;
			"=": r.code = OP_ASSIGN;
			"!": r.code = OP_NOT;
			"<": r.code = OP_LT;
			">": r.code = OP_GT;
			"&": r.code = OP_AND;
			"|": r.code = OP_OR;
			"^": r.code = OP_XOR;
			default: begin
				r.hit = 1'b0;
				r.code = OP_ELLIPSIS;
			end
		endcase
		return r;
	endfunction

	function automatic lx_op_t two_op(input logic [7:0] a, input logic [7:0] b);
		lx_op_t r;
		r.hit = 1'b1;
		case ({a, b})
			"->": r.code = OP_ARROW;
			"<<": r.code = OP_SHL;
			">>": r.code = OP_SHR;
			"<=": r.code = OP_LE;
			">=": r.code = OP_GE;
			"==": r.code = OP_EQ;
			"!=": r.code = OP_NE;
			"&&": r.code = OP_LAND;
			"||": r.code = OP_LOR;
			"++": r.code = OP_INC;
			"--": r.code = OP_DEC;
			default: begin
				r.hit = 1'b0;
				r.code = OP_ELLIPSIS;
			end
		endcase
		return r;
	endfunction

	function automatic logic [3:0] delim_code(input logic [7:0] c);
		logic [3:0] d;
		case (c)
			"(": d = {1'b1, D_LPAREN};
			")": d = {1'b1, D_RPAREN};
			"{": d = {1'b1, D_LBRACE};
			"}": d = {1'b1, D_RBRACE};
			":": d = {1'b1, D_COLON};
			",": d = {1'b1, D_COMMA};
			".": d = {1'b1, D_DOT};
			";": d = {1'b1, D_SEMI};
			default: d = 4'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: rtl/lx_if.sv
`timescale 1ns / 1ps
// input byte channel
interface lx_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] byte_value;
	modport source (output valid, output op, output byte_value, input ready);
	modport sink (input valid, input op, input byte_value, output ready);
endinterface

// result channel
interface lx_out_if;
	logic        valid;
	logic        ready;
	logic [5:0]  kind;
	logic [30:0] value;
	logic [4:0]  frac_digits;
	logic [15:0] line;
	logic [15:0] column;
	logic        last;
	modport source (output valid, output kind, output value, output frac_digits,
		output line, output column, output last, input ready);
	modport sink (input valid, input kind, input value, input frac_digits,
		input line, input column, input last, output ready);
endinterface

FILE: rtl/c_subset_lexer.sv
`timescale 1ns / 1ps
// channel  dir  payload                                          transfer
// in_ch    in   op, byte_value                                   valid & ready
// out_ch   out  kind, value, frac_digits, line, column, last     valid & ready
//
// a byte is latched when taken, then worked in decision steps with at most
// one result each; an identifier end adds a header step and a step per
// buffered char, replayed through the read port of the identifier memory.
// one byte is in work at a time; ready is low until its results are queued.
// a stalled output holds results in a pending and an output register.
// reset clears control state at once; the identifier memory is not cleared.
`include "assert_macros.svh"
module c_subset_lexer #(
	parameter int IDENT_MAX = 32,
	parameter int POS_WIDTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	lx_in_if.sink    in_ch,
	lx_out_if.source out_ch
);
	import lx_pkg::*;

	localparam int IDENT_BUF = (IDENT_MAX < 38) ? IDENT_MAX : 38;
	localparam int AW = $clog2(IDENT_BUF);
	localparam int LW = $clog2(IDENT_BUF + 1);
	localparam int PW = POS_WIDTH;

	localparam logic [3:0] M_IDLE = 4'd0;
	localparam logic [3:0] M_NUM = 4'd1;
	localparam logic [3:0] M_IDENT = 4'd2;
	localparam logic [3:0] M_ISTREAM = 4'd3;
	localparam logic [3:0] M_STR = 4'd4;
	localparam logic [3:0] M_STR_ESC = 4'd5;
	localparam logic [3:0] M_LINE = 4'd6;
	localparam logic [3:0] M_BLOCK = 4'd7;
	localparam logic [3:0] M_BLOCK_STAR = 4'd8;
	localparam logic [3:0] M_OP = 4'd9;
	localparam logic [3:0] M_ERR = 4'd10;
	localparam logic [3:0] M_REPLAY = 4'd11;
	localparam logic [3:0] M_RP_LONG = 4'd12;

	function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
		return (&p) ? p : p + PW'(1);
	endfunction

	function automatic logic [15:0] to16(input logic [PW-1:0] p);
		logic [31:0] w;
		w = 32'(p);
		return w[15:0];
	endfunction

	logic          busy_q, op_q;
	logic [7:0]    c_q, la0_q;
	logic [3:0]    mode_q, mode_d;
	logic [1:0]    la_cnt_q, la_cnt_d;
	logic [7:0]    la0_d;
	logic [LW-1:0] len_q, len_d;
	logic [KW_NUM-1:0] kw_q, kw_d;
	logic [30:0]   acc_q, acc_d;
	logic [1:0]    flags_q, flags_d;
	logic [4:0]    frac_q, frac_d;
	logic [PW-1:0] cl_q, cc_q, sl_q, sc_q, cl_d, cc_d, sl_d, sc_d;
	logic [AW-1:0] rp_idx_q, rp_idx_d;
	logic          rp_long_q, rp_long_d;

	logic          push, done, go, push_ok;
	lx_res_t       r;
	lx_buf_ctl_t   bctl;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_rdata;
	logic [PW-1:0] cc_adv;
	logic [34:0]   acc10;
	logic          acc_ovf, kw_hit;
	logic [4:0]    kw_idx;
	lx_op_t        op1, op2;
	logic [3:0]    dl;
	logic [KW_NUM-1:0] kw_first, kw_next;

	// keyword candidates, tracked as chars are buffered
	always_comb begin
		kw_hit = 1'b0;
		kw_idx = 5'd0;
		for (int k = 0; k < KW_NUM; k++) begin
			kw_first[k] = kw_char(k, 3'd0) == c_q;
			kw_next[k] = kw_q[k] && (len_q < LW'(KW_LEN[k]))
				&& kw_char(k, len_q[2:0]) == c_q;
			if (kw_q[k] && len_q == LW'(KW_LEN[k])) begin
				kw_hit = 1'b1;
				kw_idx = 5'(k);
			end
		end
	end

	assign cc_adv = inc(cc_q);
	assign acc10 = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1) + {31'd0, c_q[3:0]};
	assign acc_ovf = acc10 > {4'd0, VAL_MAX};
	assign op1 = one_op(la0_q);
	assign op2 = two_op(la0_q, c_q);
	assign dl = delim_code(c_q);

	// one decision step per cycle unless the output buffer holds back a push, at most one result
	always_comb begin
		push = 1'b0;
		done = 1'b0;
		r.kind = K_END;
		r.value = 31'd0;
		r.frac_digits = 5'd0;
		r.line = to16(sl_q);
		r.column = to16(sc_q);
		mode_d = mode_q;
		la0_d = la0_q;
		la_cnt_d = la_cnt_q;
		len_d = len_q;
		kw_d = kw_q;
		acc_d = acc_q;
		flags_d = flags_q;
		frac_d = frac_q;
		cl_d = cl_q;
		cc_d = cc_q;
		sl_d = sl_q;
		sc_d = sc_q;
		rp_idx_d = rp_idx_q;
		rp_long_d = rp_long_q;
		mem_we = 1'b0;
		mem_waddr = len_q[AW-1:0];
		mem_re = 1'b0;
		mem_raddr = '0;
		if (mode_q == M_REPLAY) begin
			// buffered identifier chars, one per step
			push = 1'b1;
			r.kind = K_ICHAR;
			r.value = 31'(mem_rdata);
			if (LW'(rp_idx_q) == len_q - LW'(1)) begin
				mode_d = rp_long_q ? M_RP_LONG : M_IDLE;
			end else begin
				rp_idx_d = rp_idx_q + AW'(1);
				mem_re = 1'b1;
				mem_raddr = rp_idx_q + AW'(1);
			end
		end else if (mode_q == M_RP_LONG) begin
			push = 1'b1;
			r.kind = K_ICHAR;
			r.value = 31'(c_q);
			cc_d = cc_adv;
			mode_d = M_ISTREAM;
			done = 1'b1;
		end else if (op_q) begin
			// end marker: close what is open, then the end token
			case (mode_q)
				M_NUM: begin
					push = 1'b1;
					r.kind = flags_q[0] ? K_FLOAT : K_INT;
					r.value = (!flags_q[0] && flags_q[1]) ? 31'd0 : acc_q;
					r.frac_digits = flags_q[0] ? frac_q : 5'd0;
					mode_d = M_IDLE;
				end
				M_IDENT: begin
					push = 1'b1;
					if (kw_hit) begin
						r.kind = K_KW;
						r.value = 31'(kw_idx);
						mode_d = M_IDLE;
					end else begin
						r.kind = K_IDENT;
						mode_d = M_REPLAY;
						rp_idx_d = '0;
						rp_long_d = 1'b0;
						mem_re = 1'b1;
					end
				end
				M_STR, M_STR_ESC: begin
					push = 1'b1;
					r.kind = K_ERR;
					r.value = 31'(E_STRING);
					mode_d = M_IDLE;
				end
				M_BLOCK, M_BLOCK_STAR: begin
					push = 1'b1;
					r.kind = K_ERR;
					r.value = 31'(E_COMMENT);
					mode_d = M_IDLE;
				end
				M_OP: begin
					push = 1'b1;
					r.kind = (la0_q == ".") ? K_DELIM : K_OP;
					r.value = (la0_q == ".") ? 31'(D_DOT) : 31'(op1.code);
					cc_d = cc_adv;
					if (la_cnt_q == 2'd2) begin
						la0_d = ".";
						la_cnt_d = 2'd1;
						sl_d = cl_q;
						sc_d = cc_adv;
					end else begin
						mode_d = M_IDLE;
					end
				end
				default: begin
					push = 1'b1;
					r.kind = K_END;
					r.line = to16(cl_q);
					r.column = to16(cc_q);
					done = 1'b1;
					mode_d = M_IDLE;
					la0_d = 8'd0;
					la_cnt_d = 2'd0;
					len_d = '0;
					acc_d = 31'd0;
					flags_d = 2'd0;
					frac_d = 5'd0;
					cl_d = '0;
					cc_d = '0;
					sl_d = '0;
					sc_d = '0;
				end
			endcase
		end else begin
			case (mode_q)
				M_IDLE: begin
					done = 1'b1;
					if (c_q == 8'h0a) begin
						cl_d = inc(cl_q);
						cc_d = '0;
					end else if (is_space(c_q)) begin
						cc_d = cc_adv;
					end else begin
						sl_d = cl_q;
						sc_d = cc_q;
						if (is_digit(c_q)) begin
							acc_d = 31'(c_q[3:0]);
							flags_d = 2'd0;
							frac_d = 5'd0;
							cc_d = cc_adv;
							mode_d = M_NUM;
						end else if (c_q == "\"") begin
							cc_d = cc_adv;
							mode_d = M_STR;
						end else if (c_q == "." || one_op(c_q).hit) begin
							la0_d = c_q;
							la_cnt_d = 2'd1;
							mode_d = M_OP;
						end else if (is_alpha(c_q)) begin
							mem_we = 1'b1;
							mem_waddr = '0;
							len_d = LW'(1);
							kw_d = kw_first;
							cc_d = cc_adv;
							mode_d = M_IDENT;
						end else if (dl[3]) begin
							push = 1'b1;
							r.kind = K_DELIM;
							r.value = 31'(dl[2:0]);
							r.line = to16(cl_q);
							r.column = to16(cc_q);
							cc_d = cc_adv;
						end else begin
							push = 1'b1;
							r.kind = K_ERR;
							r.value = 31'(E_CHAR);
							r.line = to16(cl_q);
							r.column = to16(cc_q);
							mode_d = M_ERR;
						end
					end
				end
				M_OP: begin
					if (la_cnt_q == 2'd2) begin
						push = 1'b1;
						if (c_q == ".") begin
							r.kind = K_OP;
							r.value = 31'(OP_ELLIPSIS);
							cc_d = inc(inc(cc_adv));
							la_cnt_d = 2'd0;
							mode_d = M_IDLE;
							done = 1'b1;
						end else begin
							// first dot of a pair stands alone
							r.kind = K_DELIM;
							r.value = 31'(D_DOT);
							cc_d = cc_adv;
							sl_d = cl_q;
							sc_d = cc_adv;
							la_cnt_d = 2'd1;
						end
					end else if (la0_q == "/" && (c_q == "/" || c_q == "*")) begin
						cc_d = inc(cc_adv);
						la_cnt_d = 2'd0;
						mode_d = (c_q == "/") ? M_LINE : M_BLOCK;
						done = 1'b1;
					end else if (op2.hit) begin
						push = 1'b1;
						r.kind = K_OP;
						r.value = 31'(op2.code);
						cc_d = inc(cc_adv);
						la_cnt_d = 2'd0;
						mode_d = M_IDLE;
						done = 1'b1;
					end else if (la0_q == "." && c_q == ".") begin
						la_cnt_d = 2'd2;
						done = 1'b1;
					end else begin
						push = 1'b1;
						r.kind = (la0_q == ".") ? K_DELIM : K_OP;
						r.value = (la0_q == ".") ? 31'(D_DOT) : 31'(op1.code);
						cc_d = cc_adv;
						la_cnt_d = 2'd0;
						mode_d = M_IDLE;
					end
				end
				M_NUM: begin
					if (is_digit(c_q)) begin
						if (acc_ovf) begin
							acc_d = VAL_MAX;
							flags_d[1] = 1'b1;
						end else begin
							acc_d = acc10[30:0];
						end
						if (flags_q[0] && frac_q != 5'd31)
							frac_d = frac_q + 5'd1;
						cc_d = cc_adv;
						done = 1'b1;
					end else if (c_q == "." && !flags_q[0]) begin
						flags_d[0] = 1'b1;
						cc_d = cc_adv;
						done = 1'b1;
					end else begin
						push = 1'b1;
						r.kind = flags_q[0] ? K_FLOAT : K_INT;
						r.value = (!flags_q[0] && flags_q[1]) ? 31'd0 : acc_q;
						r.frac_digits = flags_q[0] ? frac_q : 5'd0;
						mode_d = M_IDLE;
					end
				end
				M_IDENT: begin
					if (is_ident(c_q)) begin
						if (len_q < LW'(IDENT_BUF)) begin
							mem_we = 1'b1;
							len_d = len_q + LW'(1);
							kw_d = kw_next;
							cc_d = cc_adv;
							done = 1'b1;
						end else begin
							// buffer full: spill it, then stream
							push = 1'b1;
							r.kind = K_IDENT;
							mode_d = M_REPLAY;
							rp_idx_d = '0;
							rp_long_d = 1'b1;
							mem_re = 1'b1;
						end
					end else begin
						push = 1'b1;
						if (kw_hit) begin
							r.kind = K_KW;
							r.value = 31'(kw_idx);
							mode_d = M_IDLE;
						end else begin
							r.kind = K_IDENT;
							mode_d = M_REPLAY;
							rp_idx_d = '0;
							rp_long_d = 1'b0;
							mem_re = 1'b1;
						end
					end
				end
				M_ISTREAM: begin
					if (is_ident(c_q)) begin
						push = 1'b1;
						r.kind = K_ICHAR;
						r.value = 31'(c_q);
						cc_d = cc_adv;
						done = 1'b1;
					end else begin
						mode_d = M_IDLE;
					end
				end
				M_STR: begin
					if (c_q == "\"") begin
						push = 1'b1;
						r.kind = K_SEND;
						mode_d = M_IDLE;
					end else if (c_q == "\\") begin
						mode_d = M_STR_ESC;
					end else begin
						push = 1'b1;
						r.kind = K_SCHAR;
						r.value = 31'(c_q);
					end
					cc_d = cc_adv;
					done = 1'b1;
				end
				M_STR_ESC: begin
					push = 1'b1;
					r.kind = K_SCHAR;
					r.value = (c_q == "n") ? 31'h0a : (c_q == "t") ? 31'h09 : 31'(c_q);
					cc_d = cc_adv;
					mode_d = M_STR;
					done = 1'b1;
				end
				M_LINE: begin
					if (c_q == 8'h0a) begin
						mode_d = M_IDLE;
					end else begin
						cc_d = cc_adv;
						done = 1'b1;
					end
				end
				M_BLOCK, M_BLOCK_STAR: begin
					done = 1'b1;
					if (c_q == 8'h0a) begin
						cl_d = inc(cl_q);
						cc_d = '0;
						mode_d = M_BLOCK;
					end else begin
						cc_d = cc_adv;
						if (c_q == "*")
							mode_d = M_BLOCK_STAR;
						else if (c_q == "/" && mode_q == M_BLOCK_STAR)
							mode_d = M_IDLE;
						else
							mode_d = M_BLOCK;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	assign go = busy_q && (!push || push_ok);
	assign in_ch.ready = !busy_q;

	// control and lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mode_q <= M_IDLE;
			la0_q <= 8'd0;
			la_cnt_q <= 2'd0;
			len_q <= '0;
			kw_q <= '0;
			acc_q <= 31'd0;
			flags_q <= 2'd0;
			frac_q <= 5'd0;
			cl_q <= '0;
			cc_q <= '0;
			sl_q <= '0;
			sc_q <= '0;
			rp_idx_q <= '0;
			rp_long_q <= 1'b0;
		end else if (go) begin
			busy_q <= !done;
			mode_q <= mode_d;
			la0_q <= la0_d;
			la_cnt_q <= la_cnt_d;
			len_q <= len_d;
			kw_q <= kw_d;
			acc_q <= acc_d;
			flags_q <= flags_d;
			frac_q <= frac_d;
			cl_q <= cl_d;
			cc_q <= cc_d;
			sl_q <= sl_d;
			sc_q <= sc_d;
			rp_idx_q <= rp_idx_d;
			rp_long_q <= rp_long_d;
		end else if (!busy_q && in_ch.valid) begin
			busy_q <= 1'b1;
		end
	end

	// input item latch
	always_ff @(posedge clk) begin
		if (!busy_q && in_ch.valid) begin
			op_q <= in_ch.op;
			c_q <= in_ch.byte_value;
		end
	end

	assign bctl.push = push && go;
	assign bctl.step_end = done && go;
	assign bctl.res = r;

	lx_ident_mem #(
		.DEPTH(IDENT_BUF),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we && go),
		.waddr(mem_waddr),
		.wdata(c_q),
		.re(mem_re && go),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	lx_emit_buf u_buf (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(bctl),
		.push_ok(push_ok),
		.out_ch(out_ch)
	);

	`LX_ASSERT(a_replay_idx, clk, arst_n, (mode_q == M_REPLAY) |-> (LW'(rp_idx_q) < len_q))
	`LX_ASSERT(a_len_max, clk, arst_n, len_q <= LW'(IDENT_BUF))
	`LX_ASSERT(a_dot_pair, clk, arst_n, (la_cnt_q == 2'd2) |-> (la0_q == "."))
	`LX_ASSERT_NEXT(a_end_clear, clk, arst_n, go && done && op_q, cl_q == '0 && cc_q == '0)

endmodule

FILE: rtl/lx_ident_mem.sv
`timescale 1ns / 1ps
module lx_ident_mem #(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

FILE: rtl/lx_emit_buf.sv
`timescale 1ns / 1ps
module lx_emit_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  lx_pkg::lx_buf_ctl_t ctl,
	output logic               push_ok,
	lx_out_if.source           out_ch
);
	import lx_pkg::*;

	logic    ov_q, pv_q, plast_q, olast_q;
	lx_res_t pend_q, out_q;
	logic    slot_free, move;

	// the pending result learns it is last when the next one arrives or the step ends
	assign slot_free = !ov_q || out_ch.ready;
	assign push_ok = !pv_q || slot_free;
	assign move = pv_q && slot_free && (ctl.push || plast_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			pv_q <= 1'b0;
			plast_q <= 1'b0;
		end else begin
			if (move)
				ov_q <= 1'b1;
			else if (out_ch.ready)
				ov_q <= 1'b0;
			if (ctl.push) begin
				pv_q <= 1'b1;
				plast_q <= ctl.step_end;
			end else if (move) begin
				pv_q <= 1'b0;
			end else if (ctl.step_end && pv_q) begin
				plast_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.push)
			pend_q <= ctl.res;
		if (move) begin
			out_q <= pend_q;
			olast_q <= plast_q;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.kind = out_q.kind;
	assign out_ch.value = out_q.value;
	assign out_ch.frac_digits = out_q.frac_digits;
	assign out_ch.line = out_q.line;
	assign out_ch.column = out_q.column;
	assign out_ch.last = olast_q;

endmodule
